// ----- hw/rtl/csv_field_tokenizer_defines.svh -----
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSVFT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvft assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSVFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvft assertion failed");

`endif

// ----- hw/rtl/csvft_pkg.sv -----
// Types, character codes and constants of the comma-separated text tokenizer.
// No dependencies; used by every module of the block.
`default_nettype none

package csvft_pkg;

    localparam int MAX_HELD_SPACES = 63;
    localparam logic [5:0] HOLD_CAP = 6'((MAX_HELD_SPACES < 63) ? MAX_HELD_SPACES : 63);

    // Result queue: one transaction may queue two tokens.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_CR    = 2'd1,
        PEND_QUOTE = 2'd2
    } pend_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic [5:0] spaces_before;
        logic       quoted;
        logic       last;
    } out_item_t;

    typedef struct packed {
        pend_t      pending_mode;
        logic       can_end;
        logic       quote_possible;
        logic       quoted_seen;
        logic [5:0] held_spaces;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        pending_mode:   PEND_NONE,
        can_end:        1'b1,
        quote_possible: 1'b1,
        quoted_seen:    1'b0,
        held_spaces:    6'd0
    };

    // Tokens produced by one input transaction, handed to the result queue.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  item0;
        out_item_t  item1;
    } push_t;

endpackage

`default_nettype wire

// ----- hw/rtl/csvft_core.sv -----
// Parser state and single-pass token logic for one text byte per cycle in which fire is high.
// Depends on csvft_pkg and csv_field_tokenizer_defines.svh.
`default_nettype none
`include "csv_field_tokenizer_defines.svh"

module csvft_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire csvft_pkg::in_item_t item,
    output csvft_pkg::push_t        push
);

    typedef struct packed {
        csvft_pkg::parse_state_t state;
        logic                    valid;
        csvft_pkg::out_item_t    item;
    } step_res_t;

    csvft_pkg::parse_state_t state_reg;
    csvft_pkg::parse_state_t state_next;
    logic                    finished_reg;
    logic                    finished_next;
    logic [1:0]              cnt;
    csvft_pkg::out_item_t    r0;
    csvft_pkg::out_item_t    r1;

    function automatic csvft_pkg::out_item_t mk(input csvft_pkg::kind_t k,
                                                input logic [7:0] b,
                                                input logic [5:0] sp,
                                                input logic q);
        csvft_pkg::out_item_t r;
        r.kind          = k;
        r.out_byte      = b;
        r.spaces_before = sp;
        r.quoted        = q;
        r.last          = 1'b0;
        return r;
    endfunction

    function automatic csvft_pkg::parse_state_t fresh_field(input csvft_pkg::parse_state_t s);
        csvft_pkg::parse_state_t t;
        t                = s;
        t.can_end        = 1'b1;
        t.quote_possible = 1'b1;
        t.quoted_seen    = 1'b0;
        t.held_spaces    = 6'd0;
        return t;
    endfunction

    function automatic step_res_t line_step(input csvft_pkg::parse_state_t s);
        step_res_t r;
        r.valid = 1'b1;
        if (s.can_end)
        begin
            r.item  = mk(csvft_pkg::KIND_RECORD, 8'd0, s.held_spaces, s.quoted_seen);
            r.state = fresh_field(s);
        end
        else
        begin
            r.item  = mk(csvft_pkg::KIND_DATA, csvft_pkg::CH_LF, 6'd0, 1'b0);
            r.state = s;
        end
        return r;
    endfunction

    function automatic step_res_t plain_step(input csvft_pkg::parse_state_t s,
                                             input logic [7:0] b);
        step_res_t r;
        r.state = s;
        r.valid = 1'b0;
        r.item  = '0;
        case (b)
            csvft_pkg::CH_SPACE:
            begin
                if (s.quote_possible)
                begin
                    if (s.held_spaces < csvft_pkg::HOLD_CAP)
                    begin
                        r.state.held_spaces = s.held_spaces + 6'd1;
                    end
                end
                else
                begin
                    r.valid = 1'b1;
                    r.item  = mk(csvft_pkg::KIND_DATA, csvft_pkg::CH_SPACE, 6'd0, 1'b0);
                end
            end
            csvft_pkg::CH_CR:
            begin
                r.state.quoted_seen  = 1'b1;
                r.state.pending_mode = csvft_pkg::PEND_CR;
            end
            csvft_pkg::CH_LF:
            begin
                r = line_step(s);
            end
            csvft_pkg::CH_NUL:
            begin
                r.state.quoted_seen = 1'b1;
            end
            csvft_pkg::CH_QUOTE:
            begin
                r.state.can_end = 1'b0;
                if (s.quote_possible)
                begin
                    // Opening quote: any held leading spaces are dropped.
                    r.state.quote_possible = 1'b0;
                    r.state.quoted_seen    = 1'b1;
                    r.state.held_spaces    = 6'd0;
                end
                else
                begin
                    r.state.pending_mode = csvft_pkg::PEND_QUOTE;
                end
            end
            csvft_pkg::CH_COMMA:
            begin
                r.valid = 1'b1;
                if (s.can_end)
                begin
                    r.item  = mk(csvft_pkg::KIND_FIELD, 8'd0, s.held_spaces, s.quoted_seen);
                    r.state = fresh_field(s);
                end
                else
                begin
                    r.item                 = mk(csvft_pkg::KIND_DATA, b, s.held_spaces, 1'b0);
                    r.state.quote_possible = 1'b0;
                    r.state.held_spaces    = 6'd0;
                end
            end
            default:
            begin
                r.valid                = 1'b1;
                r.item                 = mk(csvft_pkg::KIND_DATA, b, s.held_spaces, 1'b0);
                r.state.quote_possible = 1'b0;
                r.state.held_spaces    = 6'd0;
            end
        endcase
        return r;
    endfunction

    always_comb
    begin
        step_res_t pr;
        pr            = '0;
        state_next    = state_reg;
        finished_next = finished_reg;
        cnt           = 2'd0;
        r0            = '0;
        r1            = '0;
        if (!finished_reg)
        begin
            state_next.pending_mode = csvft_pkg::PEND_NONE;
            if (item.end_of_input)
            begin
                if (state_reg.pending_mode == csvft_pkg::PEND_QUOTE)
                begin
                    state_next.can_end = 1'b1;
                end
                r0            = mk(csvft_pkg::KIND_END, 8'd0, state_reg.held_spaces,
                                   state_reg.quoted_seen);
                cnt           = 2'd1;
                finished_next = 1'b1;
            end
            else
            begin
                unique case (state_reg.pending_mode)
                    csvft_pkg::PEND_CR:
                    begin
                        // The held CR breaks the line; a following LF is absorbed.
                        pr         = line_step(state_next);
                        state_next = pr.state;
                        r0         = pr.item;
                        cnt        = 2'd1;
                        if (item.in_byte != csvft_pkg::CH_LF)
                        begin
                            pr         = plain_step(state_next, item.in_byte);
                            state_next = pr.state;
                            if (pr.valid)
                            begin
                                r1  = pr.item;
                                cnt = 2'd2;
                            end
                        end
                    end
                    csvft_pkg::PEND_QUOTE:
                    begin
                        case (item.in_byte) inside
                            csvft_pkg::CH_SPACE, csvft_pkg::CH_CR, csvft_pkg::CH_LF,
                            csvft_pkg::CH_COMMA:
                            begin
                                // Closing quote: the field may end here.
                                state_next.can_end = 1'b1;
                                pr         = plain_step(state_next, item.in_byte);
                                state_next = pr.state;
                                if (pr.valid)
                                begin
                                    r0  = pr.item;
                                    cnt = 2'd1;
                                end
                            end
                            csvft_pkg::CH_QUOTE:
                            begin
                                r0  = mk(csvft_pkg::KIND_DATA, csvft_pkg::CH_QUOTE, 6'd0, 1'b0);
                                cnt = 2'd1;
                            end
                            default:
                            begin
                                // A stray quote is kept as data and the field stays open.
                                r0         = mk(csvft_pkg::KIND_DATA, csvft_pkg::CH_QUOTE,
                                                6'd0, 1'b0);
                                cnt        = 2'd1;
                                pr         = plain_step(state_next, item.in_byte);
                                state_next = pr.state;
                                if (pr.valid)
                                begin
                                    r1  = pr.item;
                                    cnt = 2'd2;
                                end
                            end
                        endcase
                    end
                    default:
                    begin
                        pr         = plain_step(state_next, item.in_byte);
                        state_next = pr.state;
                        if (pr.valid)
                        begin
                            r0  = pr.item;
                            cnt = 2'd1;
                        end
                    end
                endcase
            end
        end
        r0.last = (cnt == 2'd1);
        r1.last = (cnt == 2'd2);
    end

    always_comb
    begin
        push.count = fire ? cnt : 2'd0;
        push.item0 = r0;
        push.item1 = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= csvft_pkg::PARSE_RESET;
            finished_reg <= 1'b0;
        end
        else if (fire)
        begin
            state_reg    <= state_next;
            finished_reg <= finished_next;
        end
    end

    `CSVFT_ASSERT_IMPL(a_no_tokens_after_end, clk, rst_n, finished_reg, push.count == 2'd0)
    `CSVFT_ASSERT_IMPL(a_end_token, clk, rst_n, fire && !finished_reg && item.end_of_input,
        push.count == 2'd1 && push.item0.kind == csvft_pkg::KIND_END && push.item0.last)
    `CSVFT_ASSERT_IMPL(a_push_bound, clk, rst_n, 1'b1, push.count != 2'd3)

endmodule

`default_nettype wire

// ----- hw/rtl/csvft_out_fifo.sv -----
// Small result queue that takes up to two tokens per cycle and issues one per cycle while token_ready is high.
// Depends on csvft_pkg and csv_field_tokenizer_defines.svh.
`default_nettype none
`include "csv_field_tokenizer_defines.svh"

module csvft_out_fifo
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire csvft_pkg::push_t     push,
    output logic                      room,
    output logic                      token_valid,
    input  wire logic                 token_ready,
    output csvft_pkg::out_item_t      token
);

    csvft_pkg::out_item_t                mem [csvft_pkg::FIFO_DEPTH];
    logic [csvft_pkg::PTR_W-1:0]         wr_ptr_reg;
    logic [csvft_pkg::PTR_W-1:0]         wr_ptr_next;
    logic [csvft_pkg::PTR_W-1:0]         rd_ptr_reg;
    logic [csvft_pkg::PTR_W-1:0]         rd_ptr_next;
    logic [csvft_pkg::CNT_W-1:0]         count_reg;
    logic [csvft_pkg::CNT_W-1:0]         count_next;
    logic                                pop;

    assign pop         = token_valid && token_ready;
    assign token_valid = (count_reg != '0);
    assign token       = mem[rd_ptr_reg];
    // Room for the worst case of two tokens from one transaction.
    assign room        = (count_reg <= csvft_pkg::CNT_W'(csvft_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + csvft_pkg::PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + csvft_pkg::PTR_W'(pop);
        count_next  = count_reg + csvft_pkg::CNT_W'(push.count) - csvft_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.item0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + csvft_pkg::PTR_W'(1)] <= push.item1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CSVFT_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= csvft_pkg::CNT_W'(csvft_pkg::FIFO_DEPTH))
    `CSVFT_ASSERT_IMPL(a_push_has_room, clk, rst_n, push.count != 2'd0,
        count_reg <= csvft_pkg::CNT_W'(csvft_pkg::FIFO_DEPTH - 2))
    `CSVFT_ASSERT_NEXT(a_push_seen, clk, rst_n, push.count != 2'd0 && !pop, token_valid)

endmodule

`default_nettype wire

// ----- hw/rtl/csv_field_tokenizer.sv -----
// Top level of the comma-separated text tokenizer: input register, parser, result queue.
// Depends on csvft_pkg, csvft_core and csvft_out_fifo.
//
//   Channel  Handshake                  Payload
//   item     item_valid / item_ready    csvft_pkg::in_item_t  (in_byte, end_of_input)
//   token    token_valid / token_ready  csvft_pkg::out_item_t (kind .. last)
//
// One byte is accepted per cycle while the queue has room; a token passes the input register
// and the result queue before it leaves. A byte that yields two tokens sends them one after
// the other through the single token output of the four-entry result queue.
// Reset returns the parser to the start of a field and empties the queue.
// A stalled token output fills the queue until it lacks room for two tokens, then drops item_ready.
`default_nettype none

module csv_field_tokenizer
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire csvft_pkg::in_item_t  item,
    output logic                      token_valid,
    input  wire logic                 token_ready,
    output csvft_pkg::out_item_t      token
);

    logic                  in_vld_reg;
    logic                  in_vld_next;
    csvft_pkg::in_item_t   in_item_reg;
    logic                  room;
    logic                  fire;
    csvft_pkg::push_t      push;

    // The held transaction is processed once the queue can take both of its tokens.
    assign fire        = in_vld_reg && room;
    assign item_ready  = !in_vld_reg || fire;
    assign in_vld_next = item_valid || (in_vld_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= item;
        end
    end

    csvft_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .push  (push)
    );

    csvft_out_fifo u_fifo
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .room        (room),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (token)
    );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the comma-separated text tokenizer csv_field_tokenizer.
// Depends on csvft_pkg and the block's RTL. A scoreboard class predicts the token stream
// from each accepted byte, and plain tasks drive directed, well-formed and noisy text.
`timescale 1ns / 100ps

module tb_top;

    class token_scoreboard;
        csvft_pkg::out_item_t expected_tokens[$];
        csvft_pkg::out_item_t step_tokens[$];
        csvft_pkg::pend_t     pend;
        bit                   can_close;
        bit                   quote_open_ok;
        bit                   flagged;
        bit                   done;
        logic [5:0]           held;
        int                   errors;

        function new();
            pend   = csvft_pkg::PEND_NONE;
            done   = 1'b0;
            errors = 0;
            start_field();
        endfunction

        function void start_field();
            can_close     = 1'b1;
            quote_open_ok = 1'b1;
            flagged       = 1'b0;
            held          = '0;
        endfunction

        function void add_token(csvft_pkg::kind_t k, logic [7:0] b, logic [5:0] sp, logic q);
            csvft_pkg::out_item_t t;
            t.kind          = k;
            t.out_byte      = b;
            t.spaces_before = sp;
            t.quoted        = q;
            t.last          = 1'b0;
            step_tokens.push_back(t);
        endfunction

        function void line_break();
            if (can_close)
            begin
                add_token(csvft_pkg::KIND_RECORD, 8'h00, held, flagged);
                start_field();
            end
            else
            begin
                add_token(csvft_pkg::KIND_DATA, csvft_pkg::CH_LF, 6'd0, 1'b0);
            end
        endfunction

        function void content_byte(logic [7:0] b);
            quote_open_ok = 1'b0;
            add_token(csvft_pkg::KIND_DATA, b, held, 1'b0);
            held = '0;
        endfunction

        function void plain_byte(logic [7:0] b);
            case (b)
                csvft_pkg::CH_SPACE:
                begin
                    if (quote_open_ok)
                    begin
                        if (held < csvft_pkg::HOLD_CAP)
                            held = held + 6'd1;
                    end
                    else
                    begin
                        add_token(csvft_pkg::KIND_DATA, csvft_pkg::CH_SPACE, 6'd0, 1'b0);
                    end
                end
                csvft_pkg::CH_CR:
                begin
                    flagged = 1'b1;
                    pend    = csvft_pkg::PEND_CR;
                end
                csvft_pkg::CH_LF:
                    line_break();
                csvft_pkg::CH_NUL:
                    flagged = 1'b1;
                csvft_pkg::CH_QUOTE:
                begin
                    can_close = 1'b0;
                    if (quote_open_ok)
                    begin
                        quote_open_ok = 1'b0;
                        flagged       = 1'b1;
                        held          = '0;
                    end
                    else
                    begin
                        pend = csvft_pkg::PEND_QUOTE;
                    end
                end
                csvft_pkg::CH_COMMA:
                begin
                    if (can_close)
                    begin
                        add_token(csvft_pkg::KIND_FIELD, 8'h00, held, flagged);
                        start_field();
                    end
                    else
                    begin
                        content_byte(b);
                    end
                end
                default:
                    content_byte(b);
            endcase
        endfunction

        // Works out the tokens that one accepted byte settles.
        function void note_item(csvft_pkg::in_item_t it);
            csvft_pkg::pend_t     mode;
            csvft_pkg::out_item_t t;
            if (done)
                return;
            mode = pend;
            pend = csvft_pkg::PEND_NONE;
            step_tokens.delete();
            if (it.end_of_input)
            begin
                if (mode == csvft_pkg::PEND_QUOTE)
                    can_close = 1'b1;
                add_token(csvft_pkg::KIND_END, 8'h00, held, flagged);
                done = 1'b1;
            end
            else if (mode == csvft_pkg::PEND_CR)
            begin
                line_break();
                if (it.in_byte != csvft_pkg::CH_LF)
                    plain_byte(it.in_byte);
            end
            else if (mode == csvft_pkg::PEND_QUOTE)
            begin
                case (it.in_byte) inside
                    csvft_pkg::CH_SPACE, csvft_pkg::CH_CR, csvft_pkg::CH_LF,
                    csvft_pkg::CH_COMMA:
                    begin
                        can_close = 1'b1;
                        plain_byte(it.in_byte);
                    end
                    csvft_pkg::CH_QUOTE:
                        add_token(csvft_pkg::KIND_DATA, csvft_pkg::CH_QUOTE, 6'd0, 1'b0);
                    default:
                    begin
                        add_token(csvft_pkg::KIND_DATA, csvft_pkg::CH_QUOTE, 6'd0, 1'b0);
                        plain_byte(it.in_byte);
                    end
                endcase
            end
            else
            begin
                plain_byte(it.in_byte);
            end
            if (step_tokens.size() > 0)
            begin
                t = step_tokens[step_tokens.size() - 1];
                t.last = 1'b1;
                step_tokens[step_tokens.size() - 1] = t;
            end
            foreach (step_tokens[i])
                expected_tokens.push_back(step_tokens[i]);
        endfunction

        function void check_token(csvft_pkg::out_item_t got);
            csvft_pkg::out_item_t want;
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected token: kind %0d, out_byte 0x%02h", got.kind, got.out_byte);
                errors++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected 0x%02h, actual 0x%02h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.spaces_before !== want.spaces_before)
            begin
                $error("spaces_before: expected %0d, actual %0d",
                       want.spaces_before, got.spaces_before);
                errors++;
            end
            if (got.quoted !== want.quoted)
            begin
                $error("quoted: expected %0b, actual %0b", want.quoted, got.quoted);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 item_valid  = 1'b0;
    logic                 item_ready;
    csvft_pkg::in_item_t  item        = '0;
    logic                 token_valid;
    logic                 token_ready = 1'b0;
    csvft_pkg::out_item_t token;

    token_scoreboard sb;
    int send_idle_pct = 17;
    int recv_idle_pct = 49;
    int items_sent    = 0;

    // Short directed text: extreme bytes, NUL, CRLF, a lone CR, doubled quotes,
    // quoted commas and line breaks, spaces before an opening quote and before data,
    // and a quote in the middle of an unquoted field.
    logic [7:0] opening_text [25] = '{
        8'h61, csvft_pkg::CH_COMMA, 8'hFF, csvft_pkg::CH_NUL, csvft_pkg::CH_COMMA,
        csvft_pkg::CH_CR, csvft_pkg::CH_LF,
        csvft_pkg::CH_SPACE, csvft_pkg::CH_SPACE, csvft_pkg::CH_QUOTE, 8'h63,
        csvft_pkg::CH_COMMA, csvft_pkg::CH_QUOTE, csvft_pkg::CH_QUOTE, csvft_pkg::CH_LF,
        csvft_pkg::CH_QUOTE, csvft_pkg::CH_CR,
        8'h78, csvft_pkg::CH_QUOTE, 8'h79, csvft_pkg::CH_COMMA, csvft_pkg::CH_LF,
        csvft_pkg::CH_SPACE, 8'h7A, csvft_pkg::CH_COMMA
    };

    csv_field_tokenizer dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (token)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        token_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && token_valid && token_ready)
            sb.check_token(token);
    end

    task automatic send_item(input logic [7:0] b, input logic eoi);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{in_byte: b, end_of_input: eoi};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_item('{in_byte: b, end_of_input: eoi});
        items_sent++;
    endtask

    // Holds the input off until every predicted token has been taken.
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_text_byte();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 9);
        if (r == 7)
            return csvft_pkg::CH_SPACE;
        if (r == 8)
            return 8'h80 | 8'($urandom);
        if (r == 9)
            return csvft_pkg::CH_NUL;
        do
            b = 8'($urandom_range(8'h21, 8'h7E));
        while (b == csvft_pkg::CH_COMMA || b == csvft_pkg::CH_QUOTE);
        return b;
    endfunction

    task automatic send_record();
        int nfields;
        int lead;
        int len;
        int r;
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++)
        begin
            // Now and then a run of spaces near the held count's cap, at times long enough to saturate it.
            lead = ($urandom_range(0, 15) == 0) ? $urandom_range(58, 70) : $urandom_range(0, 2);
            repeat (lead)
                send_item(csvft_pkg::CH_SPACE, 1'b0);
            len = $urandom_range(0, 5);
            if ($urandom_range(0, 1))
            begin
                send_item(csvft_pkg::CH_QUOTE, 1'b0);
                repeat (len)
                begin
                    r = $urandom_range(0, 9);
                    case (r)
                        0: send_item(csvft_pkg::CH_COMMA, 1'b0);
                        1: send_item(csvft_pkg::CH_LF, 1'b0);
                        2: send_item(csvft_pkg::CH_CR, 1'b0);
                        3:
                        begin
                            send_item(csvft_pkg::CH_CR, 1'b0);
                            send_item(csvft_pkg::CH_LF, 1'b0);
                        end
                        4:
                        begin
                            send_item(csvft_pkg::CH_QUOTE, 1'b0);
                            send_item(csvft_pkg::CH_QUOTE, 1'b0);
                        end
                        default: send_item(random_text_byte(), 1'b0);
                    endcase
                end
                send_item(csvft_pkg::CH_QUOTE, 1'b0);
                if ($urandom_range(0, 7) == 0)
                    send_item(csvft_pkg::CH_SPACE, 1'b0);
            end
            else
            begin
                repeat (len)
                    send_item(random_text_byte(), 1'b0);
            end
            if (f != nfields - 1)
                send_item(csvft_pkg::CH_COMMA, 1'b0);
        end
        r = $urandom_range(0, 2);
        if (r == 0)
            send_item(csvft_pkg::CH_LF, 1'b0);
        else if (r == 1)
            send_item(csvft_pkg::CH_CR, 1'b0);
        else
        begin
            send_item(csvft_pkg::CH_CR, 1'b0);
            send_item(csvft_pkg::CH_LF, 1'b0);
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(csvft_pkg::CH_QUOTE, 1'b0);
            else
                send_item(8'($urandom), 1'b0);
        end
    endtask

    task automatic run_random(input int target);
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) < 8)
                send_record();
            else
                send_noise();
        end
    endtask

    initial
    begin
        sb = new();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_text[i])
            send_item(opening_text[i], 1'b0);
        run_random(80);
        drain();

        send_idle_pct = 49;
        recv_idle_pct = 17;
        run_random(140);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(195);

        // Leave any open quoted field, then end the data with a quote, a letter and a CR.
        if (sb.pend == csvft_pkg::PEND_QUOTE)
            send_item(csvft_pkg::CH_COMMA, 1'b0);
        else if (!sb.can_close)
        begin
            send_item(csvft_pkg::CH_QUOTE, 1'b0);
            send_item(csvft_pkg::CH_COMMA, 1'b0);
        end
        send_item(csvft_pkg::CH_QUOTE, 1'b0);
        send_item(8'h65, 1'b0);
        send_item(csvft_pkg::CH_CR, 1'b0);
        send_item(8'($urandom), 1'b1);

        // Bytes after the end of data must be swallowed without tokens.
        repeat (3)
            send_item(8'($urandom), 1'b0);

        drain();
        repeat (20)
            @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
